>>> design/time_of_day_clock_with_alarm_slots_assert.svh
// Assertion macros for the time-of-day clock with alarm slots.
`ifndef TIME_OF_DAY_CLOCK_WITH_ALARM_SLOTS_ASSERT_SVH
`define TIME_OF_DAY_CLOCK_WITH_ALARM_SLOTS_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define TODC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("todc assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define TODC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("todc assertion failed");
`else
`define TODC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TODC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/todc_pkg.sv
// Shared types and constants for the time-of-day clock with alarm slots.
`default_nettype none
package todc_pkg;

	localparam int unsigned DAY_MINS     = 1440;
	localparam int unsigned NOON_HOURS   = 12;
	localparam int unsigned WINDOW_RESET = 10;

	typedef enum logic [1:0] {
		CMD_TICK        = 2'd0,
		CMD_SET_TIME    = 2'd1,
		CMD_WRITE_SLOT  = 2'd2,
		CMD_CLEAR_SLOTS = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MINUTE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

>>> design/time_of_day_clock_with_alarm_slots.sv
// Top level of the time-of-day clock with alarm slots.
`default_nettype none
`include "time_of_day_clock_with_alarm_slots_assert.svh"
// The block keeps the time of day as hours, minutes and seconds, starting at
// 12:00:00 after reset, and a table of SLOT_COUNT alarm slots, each a minute
// of day with a valid mark. Every input transfer carries one command: a
// one-second tick, set time, write one slot, or clear all slots. Every command
// yields exactly one output transfer giving the time after the command and the
// lowest-numbered valid slot that lies from zero to window_minutes minutes
// ahead of the current minute, counted around midnight. Out-of-range set
// values are folded back into the day, and a slot write to an index at or
// beyond SLOT_COUNT changes nothing. One command is worked on at a time: after
// an input transfer the block applies the command, then forms the current
// minute of day, then checks one slot per cycle on a single
// subtract-and-compare unit, stopping at the first hit, and then loads the
// output register. The load waits while the output register still holds a
// result that has not been taken, and the block is ready for the next
// command in the cycle after the load. The output register lets a new command
// start while the previous result still waits to be taken. The window
// register may be written at any time the block is idle; it resets to ten
// minutes.
module time_of_day_clock_with_alarm_slots #(
	parameter int SLOT_COUNT = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: the look-ahead window in minutes.
	input  wire logic        cfg_wr_en,
	input  wire logic [5:0]  cfg_wr_data,
	// Command channel.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [4:0]  set_hours,
	input  wire logic [5:0]  set_minutes,
	input  wire logic [5:0]  set_seconds,
	input  wire logic [2:0]  slot_index,
	// Result channel.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       now_hours,
	output logic [5:0]       now_minutes,
	output logic [5:0]       now_seconds,
	output logic             alarm_hit,
	output logic [2:0]       hit_slot,
	output logic [10:0]      hit_minute_of_day
);
	import todc_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Sequencer state.
	state_t state_q, state_d;

	// Captured command.
	cmd_t       cmd_q;
	logic [4:0] hh_q;
	logic [5:0] mm_q;
	logic [5:0] ss_q;
	logic [2:0] idx_q;

	// Time of day and configuration.
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;
	logic [5:0]  window_q;
	logic [10:0] nowm_q;

	// Alarm slot table: the minutes have no reset, the valid marks do.
	logic [10:0] slot_minute_q [SLOT_COUNT];
	logic        slot_valid_q  [SLOT_COUNT];

	// Scan pointer and hit record.
	logic [IDX_W-1:0] scan_q;
	logic             hit_q;
	logic [2:0]       hit_idx_q;
	logic [10:0]      hit_min_q;

	// Output register.
	logic        out_valid_q;
	logic [4:0]  out_hours_q;
	logic [5:0]  out_minutes_q;
	logic [5:0]  out_seconds_q;
	logic        out_hit_q;
	logic [2:0]  out_slot_q;
	logic [10:0] out_min_q;

	// Sequencer decodes.
	logic accept;
	logic exec_en;
	logic minute_en;
	logic scan_en;
	logic load_out;

	// Command arithmetic.
	logic [5:0]  set_sec;
	logic        sec_carry;
	logic [6:0]  min_sum;
	logic [5:0]  set_min;
	logic        min_carry;
	logic [5:0]  hour_sum;
	logic [4:0]  set_hour;
	logic [10:0] slot_raw;
	logic [10:0] slot_norm;

	// Shared subtract-and-compare unit.
	logic [10:0] scan_minute;
	logic        scan_valid;
	logic [11:0] diff;
	logic [11:0] ahead;
	logic        scan_hit;
	logic        scan_last;
	logic [IDX_W+2:0] scan_ext;

	assign accept = in_valid && in_ready;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC:   state_d = ST_MINUTE;
			ST_MINUTE: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_hit || scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer output decodes.
	always_comb begin
		in_ready  = 1'b0;
		exec_en   = 1'b0;
		minute_en = 1'b0;
		scan_en   = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready  = 1'b1;
			ST_EXEC:   exec_en   = 1'b1;
			ST_MINUTE: minute_en = 1'b1;
			ST_SCAN:   scan_en   = 1'b1;
			ST_DONE:   load_out  = !out_valid_q || out_ready;
			default:   in_ready  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The command is held for the cycles that apply it.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			hh_q  <= set_hours;
			mm_q  <= set_minutes;
			ss_q  <= set_seconds;
			idx_q <= slot_index;
		end
	end

	// Folding a set time back into the day: each field overflows its range
	// at most once, so one conditional subtraction per field is enough.
	always_comb begin
		sec_carry = (ss_q >= 6'd60);
		set_sec   = sec_carry ? (ss_q - 6'd60) : ss_q;
		min_sum   = {1'b0, mm_q} + {6'd0, sec_carry};
		min_carry = (min_sum >= 7'd60);
		set_min   = min_carry ? 6'(min_sum - 7'd60) : min_sum[5:0];
		hour_sum  = {1'b0, hh_q} + {5'd0, min_carry};
		set_hour  = (hour_sum >= 6'd24) ? 5'(hour_sum - 6'd24) : hour_sum[4:0];
	end

	// Minute of day for a slot write, folded into one day.
	always_comb begin
		slot_raw  = {hh_q, 6'd0} - {4'd0, hh_q, 2'd0} + {5'd0, mm_q};
		slot_norm = (slot_raw >= 11'(DAY_MINS)) ? (slot_raw - 11'(DAY_MINS)) : slot_raw;
	end

	// Time of day.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q <= 5'(NOON_HOURS);
			min_q  <= 6'd0;
			sec_q  <= 6'd0;
		end else if (exec_en) begin
			if (cmd_q == CMD_TICK) begin
				if (sec_q == 6'd59) begin
					sec_q <= 6'd0;
					if (min_q == 6'd59) begin
						min_q  <= 6'd0;
						hour_q <= (hour_q == 5'd23) ? 5'd0 : hour_q + 5'd1;
					end else begin
						min_q <= min_q + 6'd1;
					end
				end else begin
					sec_q <= sec_q + 6'd1;
				end
			end else if (cmd_q == CMD_SET_TIME) begin
				hour_q <= set_hour;
				min_q  <= set_min;
				sec_q  <= set_sec;
			end
		end
	end

	// Window register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 6'(WINDOW_RESET);
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	// Slot minutes.
	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (exec_en && cmd_q == CMD_WRITE_SLOT && int'(idx_q) == i) begin
				slot_minute_q[i] <= slot_norm;
			end
		end
	end

	// Slot valid marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_valid_q[i] <= 1'b0;
			end
		end else if (exec_en) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (cmd_q == CMD_CLEAR_SLOTS) begin
					slot_valid_q[i] <= 1'b0;
				end else if (cmd_q == CMD_WRITE_SLOT && int'(idx_q) == i) begin
					slot_valid_q[i] <= 1'b1;
				end
			end
		end
	end

	// The slot under the scan pointer, measured ahead of the current minute
	// around midnight and compared against the window.
	always_comb begin
		scan_minute = slot_minute_q[scan_q];
		scan_valid  = slot_valid_q[scan_q];
		diff        = {1'b0, scan_minute} - {1'b0, nowm_q};
		ahead       = diff[11] ? (diff + 12'(DAY_MINS)) : diff;
		scan_hit    = scan_en && scan_valid && (ahead <= {6'd0, window_q});
		scan_last   = (scan_q == IDX_W'(SLOT_COUNT - 1));
		scan_ext    = (IDX_W + 3)'(scan_q);
	end

	// Current minute of day, then the scan itself.
	always_ff @(posedge clk) begin
		if (minute_en) begin
			nowm_q <= {hour_q, 6'd0} - {4'd0, hour_q, 2'd0} + {5'd0, min_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			hit_q     <= 1'b0;
			hit_idx_q <= 3'd0;
			hit_min_q <= 11'd0;
		end else if (minute_en) begin
			scan_q    <= '0;
			hit_q     <= 1'b0;
			hit_idx_q <= 3'd0;
			hit_min_q <= 11'd0;
		end else if (scan_en) begin
			if (scan_hit) begin
				hit_q     <= 1'b1;
				hit_idx_q <= scan_ext[2:0];
				hit_min_q <= scan_minute;
			end else if (!scan_last) begin
				scan_q <= scan_q + IDX_W'(1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_hours_q   <= hour_q;
			out_minutes_q <= min_q;
			out_seconds_q <= sec_q;
			out_hit_q     <= hit_q;
			out_slot_q    <= hit_idx_q;
			out_min_q     <= hit_min_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign now_hours         = out_hours_q;
	assign now_minutes       = out_minutes_q;
	assign now_seconds       = out_seconds_q;
	assign alarm_hit         = out_hit_q;
	assign hit_slot          = out_slot_q;
	assign hit_minute_of_day = out_min_q;

	// A result without a hit carries zero slot and zero minute.
	`TODC_ASSERT_NOW(a_no_hit_zero, clk, arst_n, out_valid && !alarm_hit, hit_slot == 3'd0 && hit_minute_of_day == 11'd0)
	// A delivered time always lies within the day.
	`TODC_ASSERT_NOW(a_time_in_range, clk, arst_n, out_valid, now_hours < 5'd24 && now_minutes < 6'd60 && now_seconds < 6'd60)
	// An accepted command is applied in the very next cycle.
	`TODC_ASSERT_NEXT(a_accept_exec, clk, arst_n, in_valid && in_ready, state_q == ST_EXEC && !in_ready)

endmodule
`default_nettype wire
